// ----- rtl/rqr_pkg.sv -----
`default_nettype none
package rqr_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Action codes
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_QUEUED  = 2'd3;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic              shift;   // pop: every cell takes its right neighbor
    logic              append;  // first empty cell loads the key
    logic              remove;  // cell holding the key drops it
    logic [SLOT_W-1:0] key;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/rqr_cell.sv -----
`default_nettype none
module rqr_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rqr_pkg::cell_ctl_t        ctl,
  input  wire logic                      left_valid,
  input  wire logic                      right_valid,
  input  wire logic [rqr_pkg::SLOT_W-1:0] right_slot,
  output logic                           valid,
  output logic [rqr_pkg::SLOT_W-1:0]     slot
);
  import rqr_pkg::*;

  logic              valid_next;
  logic [SLOT_W-1:0] slot_next;

  // Pick the next content of this cell from the broadcast operation or the compaction rule
  always_comb begin
    valid_next = valid;
    slot_next  = slot;
    priority if (ctl.shift) begin
      valid_next = right_valid;
      slot_next  = right_slot;
    end else if (ctl.append) begin
      if (!valid && left_valid) begin
        valid_next = 1'b1;
        slot_next  = ctl.key;
      end
    end else if (ctl.remove) begin
      if (valid && slot == ctl.key) begin
        valid_next = 1'b0;
      end
    end else begin
      // Close a hole: pull the right neighbor down, or give this entry away
      if (!valid && right_valid) begin
        valid_next = 1'b1;
        slot_next  = right_slot;
      end else if (valid && !left_valid) begin
        valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    slot <= slot_next;
  end

endmodule
`default_nettype wire

// ----- rtl/ready_queue_with_removal.sv -----
`default_nettype none
// Ready queue of process slots held as a row of cells in queue order, head in
// cell zero. Each beat appends a slot at the tail, pops the head or removes a
// given slot, and answers with one result beat: popped slot, status and the
// count after the operation. The result of an accepted beat is registered
// and presented in the next cycle. Append and pop leave no hole, so those
// beats can go in back to back while no result waits downstream. A remove
// leaves a hole that walks toward the tail by one cell per cycle; the next
// beat is held off until the row is packed again. The single result
// register holds the input off for as long as a result waits downstream.
module ready_queue_with_removal (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                action,
  input  wire logic [rqr_pkg::SLOT_W-1:0] process_slot,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [rqr_pkg::SLOT_W-1:0]     popped_slot,
  output logic [1:0]                     status,
  output logic [rqr_pkg::CNT_W-1:0]      queue_count
);
  import rqr_pkg::*;

  logic [SLOT_COUNT-1:0] cell_valid;
  logic [SLOT_W-1:0]     cell_slot [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] queued_mark;
  logic [SLOT_COUNT-1:0] queued_mark_next;
  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      entry_count_next;
  logic                  out_valid_next;
  cell_ctl_t             ctl;
  logic                  busy;
  logic                  accept;
  logic [SLOT_W-1:0]     res_popped;
  logic [1:0]            res_status;

  // Hold input while a hole is still being closed or the result is stalled
  assign busy     = |(~cell_valid[SLOT_COUNT-2:0] & cell_valid[SLOT_COUNT-1:1]);
  assign in_stall = busy | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  // Decode the beat into cell control, membership and count updates
  always_comb begin
    ctl              = '0;
    ctl.key          = process_slot;
    res_popped       = '0;
    res_status       = ST_OK;
    queued_mark_next = queued_mark;
    entry_count_next = entry_count;
    unique case (action)
      ACT_APPEND: begin
        if (queued_mark[process_slot]) begin
          res_status = ST_QUEUED;
        end else begin
          ctl.append                     = accept;
          queued_mark_next[process_slot] = 1'b1;
          entry_count_next               = entry_count + 1'b1;
        end
      end
      ACT_POP: begin
        if (entry_count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_popped                     = cell_slot[0];
          ctl.shift                      = accept;
          queued_mark_next[cell_slot[0]] = 1'b0;
          entry_count_next               = entry_count - 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (!queued_mark[process_slot]) begin
          res_status = ST_ABSENT;
        end else begin
          ctl.remove                     = accept;
          queued_mark_next[process_slot] = 1'b0;
          entry_count_next               = entry_count - 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Build the row of cells, head at index zero
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic              lv;
    logic              rv;
    logic [SLOT_W-1:0] rs;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_inner_l
      assign lv = cell_valid[i-1];
    end
    if (i == SLOT_COUNT - 1) begin : g_last
      assign rv = 1'b0;
      assign rs = '0;
    end else begin : g_inner_r
      assign rv = cell_valid[i+1];
      assign rs = cell_slot[i+1];
    end
    rqr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .right_valid (rv),
      .right_slot  (rs),
      .valid       (cell_valid[i]),
      .slot        (cell_slot[i])
    );
  end

  assign out_valid_next = accept | (out_valid & out_stall);

  // Commit state and register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      queued_mark <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        queued_mark <= queued_mark_next;
        entry_count <= entry_count_next;
      end
    end
    if (accept) begin
      popped_slot <= res_popped;
      status      <= res_status;
      queue_count <= entry_count_next;
    end
  end

endmodule
`default_nettype wire
